FILE: sv/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg: shared types and constants for the 4x4 matrix inverse
// Holds widths, the sequencer state type, queue and divider interfaces and
// the minor addressing helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mi4_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int IDX_W     = 4;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = 2;
  localparam int Q_CW      = 3;
  // Magnitude of a product of up to four elements
  localparam int PROD_W    = 128;
  // Signed cofactor: |C| < 3 * 2^94
  localparam int CF_W      = 98;
  // Signed determinant: |det| < 24 * 2^124
  localparam int DET_W     = 131;
  // Quotient bits searched; a set top bit always saturates
  localparam int QBITS     = 34;
  localparam int DIV_W     = DET_W + QBITS;
  localparam int STEP_W    = 6;

  localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;
  localparam logic [1:0]       OPND_DET = 2'd3;
  localparam logic [2:0]       LAST_TERM = 3'd5;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [ELEM_W-1:0] element;
  } qent_t;

  typedef struct packed {
    logic start;
    logic neg;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [ELEM_W-1:0] value;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CF_START,
    ST_RD,
    ST_LDP,
    ST_MUL,
    ST_ACC,
    ST_DET_P,
    ST_DET_ACC,
    ST_OUT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  // Address of operand o of permutation term t in the minor that omits
  // row orow and column ocol.
  function automatic logic [IDX_W-1:0] term_addr(input logic [1:0] orow,
                                                 input logic [1:0] ocol,
                                                 input logic [2:0] t,
                                                 input logic [1:0] o);
    logic [1:0] kc;
    logic [1:0] row;
    logic [1:0] col;
    kc = 2'd0;
    unique case (t)
      3'd0:    kc = o;
      3'd1:    kc = (o == 2'd0) ? 2'd1 : ((o == 2'd1) ? 2'd2 : 2'd0);
      3'd2:    kc = (o == 2'd0) ? 2'd2 : ((o == 2'd1) ? 2'd0 : 2'd1);
      3'd3:    kc = (o == 2'd0) ? 2'd0 : ((o == 2'd1) ? 2'd2 : 2'd1);
      3'd4:    kc = (o == 2'd0) ? 2'd1 : ((o == 2'd1) ? 2'd0 : 2'd2);
      3'd5:    kc = (o == 2'd0) ? 2'd2 : ((o == 2'd1) ? 2'd1 : 2'd0);
      default: kc = 2'd0;
    endcase
    row = (o < orow) ? o : o + 2'd1;
    col = (kc < ocol) ? kc : kc + 2'd1;
    return {row, col};
  endfunction

endpackage

`default_nettype wire

FILE: sv/matrix_inverse_4x4.sv
// The single 32x32 multiplier doing all cofactor terms and the one-bit-per-cycle
// divider set the time from the sixteenth element of a matrix to its last
// result, which is shorter for a singular matrix. One element per cycle enters
// the input queue while it is not full; the next matrix is read from the queue
// only after the last result of the one before has been issued. Reset clears
// all control state; the matrix store is rewritten by every matrix.
// ----------------------------------------------------------------------------
// matrix_inverse_4x4: 4x4 fixed-point matrix inverse by the adjugate
// Front tags elements, a queue decouples it from the cofactor engine.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_inverse_4x4 (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic signed [31:0]          element_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic signed [31:0]               inv_element_o,
  output logic                             last_o,
  output logic                             singular_o,
  output logic                             saturated_o
);

  logic            q_wr;
  logic            q_full;
  logic            q_rd;
  logic            q_empty;
  mi4_pkg::qent_t  q_wdata;
  mi4_pkg::qent_t  q_rdata;
  logic [31:0]     inv_raw;

  mi4_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .element_i (element_i),
    .full      (full),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .q_data_o  (q_wdata)
  );

  mi4_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wdata),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_rdata),
    .empty_o   (q_empty)
  );

  mi4_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_data_i      (q_rdata),
    .q_empty_i     (q_empty),
    .q_rd_o        (q_rd),
    .empty         (empty),
    .pop           (pop),
    .inv_element_o (inv_raw),
    .last_o        (last_o),
    .singular_o    (singular_o),
    .saturated_o   (saturated_o)
  );

  assign inv_element_o = $signed(inv_raw);

endmodule

`default_nettype wire

FILE: sv/mi4_queue.sv
// ----------------------------------------------------------------------------
// mi4_queue: element queue between front and back
// Small first-in first-out buffer of tagged elements.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  mi4_pkg::qent_t     wr_data_i,
  output logic               full_o,
  input  wire logic          rd_i,
  output mi4_pkg::qent_t     rd_data_o,
  output logic               empty_o
);

  mi4_pkg::qent_t                mem_q [mi4_pkg::Q_DEPTH];
  logic [mi4_pkg::Q_AW-1:0]      wp_q, wp_d;
  logic [mi4_pkg::Q_AW-1:0]      rp_q, rp_d;
  logic [mi4_pkg::Q_CW-1:0]      cnt_q, cnt_d;
  logic                          do_wr;
  logic                          do_rd;

  assign full_o    = (cnt_q == mi4_pkg::Q_CW'(mi4_pkg::Q_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rp_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  // Advance pointers and fill count
  always_comb begin
    wp_d  = do_wr ? wp_q + 1'b1 : wp_q;
    rp_d  = do_rd ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mi4_front.sv
// ----------------------------------------------------------------------------
// mi4_front: input side of the matrix inverse
// Accepts elements and tags each with its row-major position.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  input  wire logic [mi4_pkg::ELEM_W-1:0]    element_i,
  output logic                               full,
  input  wire logic                          q_full_i,
  output logic                               q_wr_o,
  output mi4_pkg::qent_t                     q_data_o
);

  logic [mi4_pkg::IDX_W-1:0] load_cnt_q, load_cnt_d;

  assign full             = q_full_i;
  assign q_wr_o           = push && !q_full_i;
  assign q_data_o.idx     = load_cnt_q;
  assign q_data_o.element = element_i;

  // Advance the position on each accepted item, wrap after sixteen
  always_comb begin
    load_cnt_d = q_wr_o ? load_cnt_q + 1'b1 : load_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
    end else begin
      load_cnt_q <= load_cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mi4_div.sv
// ----------------------------------------------------------------------------
// mi4_div: saturating quotient unit
// Restoring division, one quotient bit per cycle, with sign and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  mi4_pkg::div_req_t                req_i,
  input  wire logic [mi4_pkg::DIV_W-1:0]   num_i,
  input  wire logic [mi4_pkg::DIV_W-1:0]   den_i,
  output mi4_pkg::div_rsp_t                rsp_o
);

  logic [mi4_pkg::DIV_W-1:0]  rem_q, rem_d;
  logic [mi4_pkg::DIV_W-1:0]  dsh_q, dsh_d;
  logic [mi4_pkg::QBITS-1:0]  quo_q, quo_d;
  logic [mi4_pkg::STEP_W-1:0] step_q, step_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic                       neg_q, neg_d;
  logic                       ge;
  logic                       sat_pos;
  logic                       sat_neg;

  assign ge = (rem_q >= dsh_q);

  // One subtract-and-compare step per cycle
  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = num_i;
      dsh_d  = den_i << (mi4_pkg::QBITS - 1);
      quo_d  = '0;
      step_d = mi4_pkg::STEP_W'(mi4_pkg::QBITS);
      busy_d = 1'b1;
      neg_d  = req_i.neg;
    end else if (busy_q) begin
      rem_d  = ge ? rem_q - dsh_q : rem_q;
      quo_d  = {quo_q[mi4_pkg::QBITS-2:0], ge};
      dsh_d  = dsh_q >> 1;
      step_d = step_q - 1'b1;
      if (step_q == mi4_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  // Clamp to the signed 32-bit range; an exact -2^31 is in range
  assign sat_pos = |quo_q[mi4_pkg::QBITS-1:31];
  assign sat_neg = (|quo_q[mi4_pkg::QBITS-1:32]) || (quo_q[31] && (|quo_q[30:0]));

  always_comb begin
    rsp_o.done = done_q;
    if (neg_q) begin
      rsp_o.sat   = sat_neg;
      rsp_o.value = sat_neg ? 32'h8000_0000 : 32'd0 - quo_q[31:0];
    end else begin
      rsp_o.sat   = sat_pos;
      rsp_o.value = sat_pos ? 32'h7FFF_FFFF : quo_q[31:0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/mi4_back.sv
// ----------------------------------------------------------------------------
// mi4_back: cofactor engine of the matrix inverse
// Stores the matrix, forms cofactors and the determinant with one shared
// 32x32 multiplier, divides through mi4_div and holds one result.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  mi4_pkg::qent_t                   q_data_i,
  input  wire logic                        q_empty_i,
  output logic                             q_rd_o,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [mi4_pkg::ELEM_W-1:0]       inv_element_o,
  output logic                             last_o,
  output logic                             singular_o,
  output logic                             saturated_o
);

  localparam int PW = mi4_pkg::PROD_W;

  mi4_pkg::state_e              state_q, state_d;
  logic                         det_phase_q, det_phase_d;
  logic [mi4_pkg::IDX_W-1:0]    oidx_q, oidx_d;
  logic [2:0]                   t_q, t_d;
  logic [1:0]                   opnd_q, opnd_d;
  logic [2:0]                   plen_q, plen_d;
  logic [2:0]                   k_q, k_d;
  logic [PW-1:0]                p_q, p_d;
  logic [PW-1:0]                n_q, n_d;
  logic [63:0]                  pp_q, pp_d;
  logic                         sgn_q, sgn_d;
  logic signed [mi4_pkg::CF_W-1:0]  cf_q, cf_d;
  logic signed [mi4_pkg::DET_W-1:0] det_q, det_d;
  logic [mi4_pkg::ELEM_W-1:0]   mem_q [16];
  logic [mi4_pkg::ELEM_W-1:0]   rd_q;
  logic                         out_valid_q, out_valid_d;
  logic [mi4_pkg::ELEM_W-1:0]   out_val_q;
  logic                         out_last_q, out_sing_q, out_sat_q;

  logic [1:0]                   orow, ocol;
  logic                         cof_neg;
  logic [mi4_pkg::IDX_W-1:0]    rd_addr;
  logic [31:0]                  m_mag;
  logic [31:0]                  p_limb;
  logic [1:0]                   km1;
  logic [PW-1:0]                n_add;
  logic [mi4_pkg::CF_W-1:0]     cf_mag;
  logic [mi4_pkg::DET_W-1:0]    det_mag;
  logic                         det_zero;
  logic                         pop_acc;
  logic                         out_load;
  logic                         term_neg;
  mi4_pkg::div_req_t            div_req;
  mi4_pkg::div_rsp_t            div_rsp;

  // Minor selection: row 0 for the determinant, transposed for results
  assign orow    = det_phase_q ? 2'd0 : oidx_q[1:0];
  assign ocol    = det_phase_q ? oidx_q[1:0] : oidx_q[3:2];
  assign cof_neg = orow[0] ^ ocol[0];
  assign rd_addr = (opnd_q == mi4_pkg::OPND_DET) ? {2'b00, oidx_q[1:0]}
                 : mi4_pkg::term_addr(orow, ocol, t_q, opnd_q);

  assign m_mag    = rd_q[31] ? 32'd0 - rd_q : rd_q;
  assign p_limb   = p_q[{k_q[1:0], 5'd0} +: 32];
  assign km1      = k_q[1:0] - 2'd1;
  assign n_add    = PW'(pp_q) << {km1, 5'd0};
  assign cf_mag   = cf_q[mi4_pkg::CF_W-1] ? mi4_pkg::CF_W'(-cf_q) : mi4_pkg::CF_W'(cf_q);
  assign det_mag  = det_q[mi4_pkg::DET_W-1] ? mi4_pkg::DET_W'(-det_q)
                  : mi4_pkg::DET_W'(det_q);
  assign det_zero = (det_q == '0);
  assign term_neg = sgn_q ^ (t_q >= 3'd3) ^ cof_neg;

  assign pop_acc  = pop && out_valid_q;
  assign out_load = (state_q == mi4_pkg::ST_EMIT) && (!out_valid_q || pop_acc);
  assign q_rd_o   = (state_q == mi4_pkg::ST_LOAD) && !q_empty_i;

  assign empty         = !out_valid_q;
  assign inv_element_o = out_val_q;
  assign last_o        = out_last_q;
  assign singular_o    = out_sing_q;
  assign saturated_o   = out_sat_q;

  assign div_req.start = (state_q == mi4_pkg::ST_DIV_GO);
  assign div_req.neg   = cf_q[mi4_pkg::CF_W-1] ^ det_q[mi4_pkg::DET_W-1];

  mi4_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (mi4_pkg::DIV_W'(cf_mag) << (2 * mi4_pkg::FRAC_BITS)),
    .den_i  (mi4_pkg::DIV_W'(det_mag)),
    .rsp_o  (div_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mi4_pkg::ST_LOAD: begin
        if (!q_empty_i && q_data_i.idx == mi4_pkg::LAST_IDX) begin
          state_d = mi4_pkg::ST_CF_START;
        end
      end
      mi4_pkg::ST_CF_START: state_d = mi4_pkg::ST_RD;
      mi4_pkg::ST_RD: begin
        state_d = (opnd_q == 2'd0) ? mi4_pkg::ST_LDP : mi4_pkg::ST_MUL;
      end
      mi4_pkg::ST_LDP: state_d = mi4_pkg::ST_RD;
      mi4_pkg::ST_MUL: begin
        if (k_q == plen_q) begin
          if (opnd_q == mi4_pkg::OPND_DET) begin
            state_d = mi4_pkg::ST_DET_ACC;
          end else if (opnd_q == 2'd2) begin
            state_d = mi4_pkg::ST_ACC;
          end else begin
            state_d = mi4_pkg::ST_RD;
          end
        end
      end
      mi4_pkg::ST_ACC: begin
        if (t_q == mi4_pkg::LAST_TERM) begin
          state_d = det_phase_q ? mi4_pkg::ST_DET_P : mi4_pkg::ST_DIV_GO;
        end else begin
          state_d = mi4_pkg::ST_RD;
        end
      end
      mi4_pkg::ST_DET_P:   state_d = mi4_pkg::ST_RD;
      mi4_pkg::ST_DET_ACC: begin
        state_d = (oidx_q[1:0] == 2'd3) ? mi4_pkg::ST_OUT : mi4_pkg::ST_CF_START;
      end
      mi4_pkg::ST_OUT: begin
        state_d = det_zero ? mi4_pkg::ST_EMIT : mi4_pkg::ST_CF_START;
      end
      mi4_pkg::ST_DIV_GO:   state_d = mi4_pkg::ST_DIV_WAIT;
      mi4_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = mi4_pkg::ST_EMIT;
        end
      end
      mi4_pkg::ST_EMIT: begin
        if (out_load) begin
          state_d = (oidx_q == mi4_pkg::LAST_IDX) ? mi4_pkg::ST_LOAD : mi4_pkg::ST_OUT;
        end
      end
      default: state_d = mi4_pkg::ST_LOAD;
    endcase
  end

  // Datapath and counters
  always_comb begin
    det_phase_d = det_phase_q;
    oidx_d      = oidx_q;
    t_d         = t_q;
    opnd_d      = opnd_q;
    plen_d      = plen_q;
    k_d         = k_q;
    p_d         = p_q;
    n_d         = n_q;
    pp_d        = 64'(p_limb) * 64'(m_mag);
    sgn_d       = sgn_q;
    cf_d        = cf_q;
    det_d       = det_q;
    out_valid_d = pop_acc ? 1'b0 : out_valid_q;
    unique case (state_q)
      mi4_pkg::ST_LOAD: begin
        if (!q_empty_i && q_data_i.idx == mi4_pkg::LAST_IDX) begin
          det_phase_d = 1'b1;
          oidx_d      = '0;
          det_d       = '0;
        end
      end
      mi4_pkg::ST_CF_START: begin
        cf_d   = '0;
        t_d    = '0;
        opnd_d = '0;
      end
      mi4_pkg::ST_RD: begin
        k_d = '0;
      end
      mi4_pkg::ST_LDP: begin
        p_d    = PW'(m_mag);
        sgn_d  = rd_q[31];
        plen_d = 3'd1;
        opnd_d = 2'd1;
      end
      mi4_pkg::ST_MUL: begin
        // Limb-serial product: issue one partial product, add the previous
        n_d = (k_q == '0) ? '0 : n_q + n_add;
        if (k_q == plen_q) begin
          p_d    = n_q + n_add;
          plen_d = plen_q + 3'd1;
          sgn_d  = sgn_q ^ rd_q[31];
          if (opnd_q == 2'd1) begin
            opnd_d = 2'd2;
          end
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      mi4_pkg::ST_ACC: begin
        if (term_neg) begin
          cf_d = cf_q - $signed(mi4_pkg::CF_W'(p_q[95:0]));
        end else begin
          cf_d = cf_q + $signed(mi4_pkg::CF_W'(p_q[95:0]));
        end
        t_d    = t_q + 3'd1;
        opnd_d = '0;
      end
      mi4_pkg::ST_DET_P: begin
        p_d    = PW'(cf_mag);
        sgn_d  = cf_q[mi4_pkg::CF_W-1];
        plen_d = 3'd3;
        opnd_d = mi4_pkg::OPND_DET;
      end
      mi4_pkg::ST_DET_ACC: begin
        if (sgn_q) begin
          det_d = det_q - $signed(mi4_pkg::DET_W'(p_q));
        end else begin
          det_d = det_q + $signed(mi4_pkg::DET_W'(p_q));
        end
        if (oidx_q[1:0] == 2'd3) begin
          det_phase_d = 1'b0;
          oidx_d      = '0;
        end else begin
          oidx_d = oidx_q + 1'b1;
        end
      end
      mi4_pkg::ST_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          oidx_d      = oidx_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mi4_pkg::ST_LOAD;
      det_phase_q <= 1'b0;
      oidx_q      <= '0;
      t_q         <= '0;
      opnd_q      <= '0;
      plen_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      det_phase_q <= det_phase_d;
      oidx_q      <= oidx_d;
      t_q         <= t_d;
      opnd_q      <= opnd_d;
      plen_q      <= plen_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload: products, sums and the result register
  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    n_q   <= n_d;
    pp_q  <= pp_d;
    sgn_q <= sgn_d;
    cf_q  <= cf_d;
    det_q <= det_d;
    if (out_load) begin
      out_val_q  <= det_zero ? '0 : div_rsp.value;
      out_sat_q  <= det_zero ? 1'b0 : div_rsp.sat;
      out_sing_q <= det_zero;
      out_last_q <= (oidx_q == mi4_pkg::LAST_IDX);
    end
  end

  // Matrix store: write on load, registered read for the sequencer
  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      mem_q[q_data_i.idx] <= q_data_i.element;
    end
    if (state_q == mi4_pkg::ST_RD) begin
      rd_q <= mem_q[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/mi4_checker.sv
// ----------------------------------------------------------------------------
// mi4_checker: port-level checks for the matrix inverse
// Watches the result side and binds to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] inv_element_o,
  input wire logic        last_o,
  input wire logic        singular_o,
  input wire logic        saturated_o
);

  // Hold a waiting item until it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(inv_element_o) && $stable(last_o)))
    else $error("result changed while waiting");

  // Singular matrix gives zero elements, never clamped
  a_sing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && singular_o) |-> (inv_element_o == 32'd0 && !saturated_o))
    else $error("singular result not zero");

  // Clamp only to the range ends
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && saturated_o) |->
      (inv_element_o == 32'h7FFF_FFFF || inv_element_o == 32'h8000_0000))
    else $error("saturated value not at range end");

  // Singular flag stays constant through a matrix
  a_sing_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> (empty || singular_o == $past(singular_o)))
    else $error("singular flag changed within a matrix");

endmodule

bind matrix_inverse_4x4 mi4_checker u_mi4_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .inv_element_o (inv_element_o),
  .last_o        (last_o),
  .singular_o    (singular_o),
  .saturated_o   (saturated_o)
);

`default_nettype wire
